[rtl/dmxr_pkg.sv]
// dmxr_pkg: shared types and constants for the dmx frame receiver
// no dependencies
package dmxr_pkg;

  localparam int SLOT_COUNT_DEF = 512;

  localparam int ADDR_W = 9;
  localparam int TMO_W  = 16;
  localparam int CFG_W  = 16;
  localparam int CNT_W  = 32;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_BREAK = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [0:0] REG_START_ADDRESS = 1'd0;
  localparam logic [0:0] REG_TIMEOUT_TICKS = 1'd1;

  localparam logic [ADDR_W-1:0] START_ADDRESS_RST = 9'd1;
  localparam logic [TMO_W-1:0]  TIMEOUT_TICKS_RST = 16'd1000;

  localparam logic [7:0]       START_CODE = 8'h00;
  localparam logic [TMO_W-1:0] QUIET_MAX  = 16'hffff;

  typedef struct packed {
    logic       awaiting_break;
    logic [7:0] held_position;
    logic [7:0] position;
    logic [7:0] speed;
    logic [CNT_W-1:0] frame_counter;
    logic       valid_flag;
    logic [TMO_W-1:0] quiet_ticks;
  } dmxr_state_t;

  typedef struct packed {
    logic changed;
    logic lost;
  } dmxr_flags_t;

endpackage

[rtl/dmx_frame_receiver.sv]
// dmx_frame_receiver: dmx512 receiver that captures a position/speed slot pair
// depends on dmxr_pkg and dmxr_update
//
//   port group  dir  handshake         payload
//   in_         in   in_valid/in_stall   in_kind, in_rx_byte
//   out_        out  out_valid/out_stall position, speed, flags, frames_seen
//   cfg_        in   cfg_we             cfg_index, cfg_wdata
//
// one word per cycle while in_stall is low; a word waits in the input register,
// the state update runs between it and the result register
// the input register refills while a result waits, so in_stall rises only
// when both registers hold words and out_stall is high
// rst_n is synchronous; config registers reset to address 1 and 1000 ticks
module dmx_frame_receiver #(
  parameter int SLOT_COUNT = dmxr_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_kind,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_position,
  output logic [7:0]                   out_speed,
  output logic                         out_data_valid,
  output logic                         out_changed,
  output logic                         out_signal_lost,
  output logic [dmxr_pkg::CNT_W-1:0]   out_frames_seen,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [dmxr_pkg::CFG_W-1:0]   cfg_wdata
);
  import dmxr_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT + 2);

  logic              in_valid_r;
  logic [1:0]        kind_r;
  logic [7:0]        byte_r;
  logic              out_valid_r;
  logic              adv;
  logic              in_take;

  logic [ADDR_W-1:0] start_address_r;
  logic [TMO_W-1:0]  timeout_ticks_r;

  dmxr_state_t       st_r;
  dmxr_state_t       st_nxt;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  dmxr_flags_t       flags;

  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  dmxr_update #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W)
  ) u_update (
    .kind          (kind_r),
    .rx_byte       (byte_r),
    .start_address (start_address_r),
    .timeout_ticks (timeout_ticks_r),
    .st            (st_r),
    .slot          (slot_r),
    .st_nxt        (st_nxt),
    .slot_nxt      (slot_nxt),
    .flags         (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      start_address_r <= START_ADDRESS_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
      st_r            <= '{awaiting_break: 1'b1, default: '0};
      slot_r          <= '0;
    end else begin
      in_valid_r  <= in_take || (in_valid_r && !adv);
      out_valid_r <= adv || (out_valid_r && out_stall);
      if (cfg_we) begin
        case (cfg_index)
          REG_START_ADDRESS: start_address_r <= cfg_wdata[ADDR_W-1:0];
          REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata[TMO_W-1:0];
          default: start_address_r <= start_address_r;
        endcase
      end
      if (adv) begin
        st_r   <= st_nxt;
        slot_r <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r <= in_kind;
      byte_r <= in_rx_byte;
    end
    if (adv) begin
      out_position    <= st_nxt.position;
      out_speed       <= st_nxt.speed;
      out_data_valid  <= st_nxt.valid_flag;
      out_changed     <= flags.changed;
      out_signal_lost <= flags.lost;
      out_frames_seen <= st_nxt.frame_counter;
    end
  end

  assign out_valid = out_valid_r;

  a_lost_clears_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_signal_lost |-> !out_data_valid)
    else $error("signal_lost with data_valid set");

  a_change_counts_frame : assert property (@(posedge clk) disable iff (!rst_n)
    adv && flags.changed |-> st_nxt.frame_counter == st_r.frame_counter + CNT_W'(1))
    else $error("position or speed changed without a frame");

  a_lost_only_on_tick : assert property (@(posedge clk) disable iff (!rst_n)
    adv && kind_r != KIND_TICK |-> !flags.lost)
    else $error("signal_lost outside a tick");

  a_stall_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r)
    else $error("input stalled with a free register");

  a_slot_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    10'(slot_r) <= 10'(SLOT_COUNT + 1))
    else $error("slot index out of range");

endmodule

[rtl/dmxr_update.sv]
// dmxr_update: next-state logic for one line event (byte, break or tick)
// depends on dmxr_pkg
module dmxr_update #(
  parameter int SLOT_COUNT = dmxr_pkg::SLOT_COUNT_DEF,
  parameter int SLOT_W     = $clog2(SLOT_COUNT + 2)
) (
  input  logic [1:0]                   kind,
  input  logic [7:0]                   rx_byte,
  input  logic [dmxr_pkg::ADDR_W-1:0]  start_address,
  input  logic [dmxr_pkg::TMO_W-1:0]   timeout_ticks,
  input  dmxr_pkg::dmxr_state_t        st,
  input  logic [SLOT_W-1:0]            slot,
  output dmxr_pkg::dmxr_state_t        st_nxt,
  output logic [SLOT_W-1:0]            slot_nxt,
  output dmxr_pkg::dmxr_flags_t        flags
);
  import dmxr_pkg::*;

  logic [9:0]       slot_ext;
  logic [9:0]       sa_ext;
  logic [9:0]       sa_next;
  logic [TMO_W:0]   quiet_inc;
  logic             is_zero;

  assign slot_ext  = 10'(slot);
  assign sa_ext    = 10'(start_address);
  assign sa_next   = sa_ext + 10'd1;
  assign quiet_inc = {1'b0, st.quiet_ticks} + {{TMO_W{1'b0}}, 1'b1};
  assign is_zero   = (rx_byte == START_CODE);

  always_comb begin
    st_nxt     = st;
    slot_nxt   = slot;
    flags.lost = 1'b0;
    case (kind)
      KIND_BYTE: begin
        if (st.awaiting_break && !is_zero) begin
          st_nxt = st;
        end else if (st.awaiting_break || slot == '0) begin
          if (is_zero) begin
            st_nxt.awaiting_break = 1'b0;
            slot_nxt = SLOT_W'(1);
            if (start_address == '0) begin
              st_nxt.held_position = rx_byte;
            end
          end else begin
            st_nxt.awaiting_break = 1'b1;
          end
        end else if (slot_ext <= 10'(SLOT_COUNT)) begin
          slot_nxt = slot + SLOT_W'(1);
          if (slot_ext == sa_ext) begin
            st_nxt.held_position = rx_byte;
          end else if (slot_ext == sa_next) begin
            st_nxt.position      = st.held_position;
            st_nxt.speed         = rx_byte;
            st_nxt.frame_counter = st.frame_counter + CNT_W'(1);
            st_nxt.valid_flag    = 1'b1;
            st_nxt.quiet_ticks   = '0;
          end else if (slot_ext > sa_next) begin
            st_nxt.quiet_ticks = '0;
          end
        end
      end
      KIND_BREAK: begin
        st_nxt.awaiting_break = 1'b0;
        slot_nxt = '0;
      end
      KIND_TICK: begin
        if (st.valid_flag && (quiet_inc > {1'b0, timeout_ticks})) begin
          st_nxt.valid_flag = 1'b0;
          flags.lost = 1'b1;
        end
        st_nxt.quiet_ticks = quiet_inc[TMO_W] ? QUIET_MAX : quiet_inc[TMO_W-1:0];
      end
      default: begin
        st_nxt = st;
      end
    endcase
    flags.changed = (st_nxt.position != st.position) || (st_nxt.speed != st.speed);
  end

endmodule

[verif/dmx_frame_receiver_tb.sv]
// dmx_frame_receiver_tb: self-checking testbench for the dmx frame receiver
// drives line events with random gaps and output stalls, predicts each status word
// depends on dmxr_pkg and the dmx_frame_receiver rtl
module dmx_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmxr_pkg::*;

  localparam int SLOT_COUNT = SLOT_COUNT_DEF;
  localparam int N_DIRECTED = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [7:0]       position;
    logic [7:0]       speed;
    logic             data_valid;
    logic             changed;
    logic             signal_lost;
    logic [CNT_W-1:0] frames_seen;
  } rx_status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] rx_byte;
    logic       typed;
    rx_status_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = KIND_BYTE;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_position;
  logic [7:0] out_speed;
  logic out_data_valid;
  logic out_changed;
  logic out_signal_lost;
  logic [CNT_W-1:0] out_frames_seen;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_START_ADDRESS;
  logic [CFG_W-1:0] cfg_wdata = '0;

  dmx_frame_receiver #(.SLOT_COUNT(SLOT_COUNT)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_position(out_position),
    .out_speed(out_speed), .out_data_valid(out_data_valid), .out_changed(out_changed),
    .out_signal_lost(out_signal_lost), .out_frames_seen(out_frames_seen),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the receiver state and its registers
  logic [ADDR_W-1:0] sh_addr = START_ADDRESS_RST;
  logic [TMO_W-1:0]  sh_tmo = TIMEOUT_TICKS_RST;
  logic              sh_wait_break = 1'b1;
  logic [9:0]        sh_slot = '0;
  logic [7:0]        sh_held = '0;
  logic [7:0]        sh_pos = '0;
  logic [7:0]        sh_spd = '0;
  logic [CNT_W-1:0]  sh_frames = '0;
  logic              sh_valid = 1'b0;
  logic [TMO_W-1:0]  sh_quiet = '0;

  rx_status_t status_pending[$];
  dir_row_t   directed_rows[N_DIRECTED];
  int hold_left = 0;
  int idle_cycles = 0;
  int errors = 0;
  int words_sent = 0;
  int results_checked = 0;
  int timeouts_seen = 0;
  int settings_run = 0;

  function automatic rx_status_t advance_receiver(input logic [1:0] k, input logic [7:0] b);
    rx_status_t r;
    logic [7:0] old_pos;
    logic [7:0] old_spd;
    logic [9:0] s;
    logic [9:0] a;
    logic [16:0] nxt;
    old_pos = sh_pos;
    old_spd = sh_spd;
    a = {1'b0, sh_addr};
    r.signal_lost = 1'b0;
    case (k)
      KIND_BYTE: begin
        if (!(sh_wait_break && b != START_CODE)) begin
          if (sh_wait_break) begin
            sh_wait_break = 1'b0;
            sh_slot = '0;
          end
          if (sh_slot == 0) begin
            if (b == START_CODE) begin
              if (sh_addr == 0) sh_held = b;
              sh_slot = 10'd1;
            end else begin
              sh_wait_break = 1'b1;
            end
          end else if (sh_slot <= SLOT_COUNT) begin
            s = sh_slot;
            sh_slot = s + 10'd1;
            if (s == a) begin
              sh_held = b;
            end else if (s == a + 10'd1) begin
              sh_pos = sh_held;
              sh_spd = b;
              sh_frames = sh_frames + 1'b1;
              sh_valid = 1'b1;
              sh_quiet = '0;
            end else if (s > a + 10'd1) begin
              sh_quiet = '0;
            end
          end
        end
      end
      KIND_BREAK: begin
        sh_wait_break = 1'b0;
        sh_slot = '0;
      end
      KIND_TICK: begin
        nxt = {1'b0, sh_quiet} + 17'd1;
        if (sh_valid && nxt > {1'b0, sh_tmo}) begin
          sh_valid = 1'b0;
          r.signal_lost = 1'b1;
        end
        sh_quiet = (nxt > {1'b0, QUIET_MAX}) ? QUIET_MAX : nxt[TMO_W-1:0];
      end
      default: ;
    endcase
    r.position = sh_pos;
    r.speed = sh_spd;
    r.data_valid = sh_valid;
    r.changed = (sh_pos != old_pos) || (sh_spd != old_spd);
    r.frames_seen = sh_frames;
    return r;
  endfunction

  function automatic dir_row_t lit(input logic [1:0] k, input logic [7:0] b,
                                   input logic [7:0] pos, input logic [7:0] spd,
                                   input logic dv, input logic ch, input logic lost,
                                   input logic [CNT_W-1:0] fr);
    dir_row_t r;
    r.kind = k;
    r.rx_byte = b;
    r.typed = 1'b1;
    r.want = '{pos, spd, dv, ch, lost, fr};
    return r;
  endfunction

  function automatic dir_row_t chk(input logic [1:0] k, input logic [7:0] b);
    dir_row_t r;
    r = '0;
    r.kind = k;
    r.rx_byte = b;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(input logic [1:0] k, input logic [7:0] b,
                           input logic typed, input rx_status_t lit_want);
    rx_status_t st;
    int gap;
    logic held;
    st = advance_receiver(k, b);
    status_pending.push_back(typed ? lit_want : st);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_rx_byte <= b;
    do begin
      @(negedge clk);
      held = in_stall;
      @(posedge clk);
    end while (held);
    words_sent++;
  endtask

  task automatic send_frame(input int n_data, input bit lead_break, input logic [7:0] sc);
    if (lead_break) send_word(KIND_BREAK, rand_byte(), 1'b0, '0);
    send_word(KIND_BYTE, sc, 1'b0, '0);
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(0, 5) == 0) send_word(KIND_TICK, rand_byte(), 1'b0, '0);
      send_word(KIND_BYTE, rand_byte(), 1'b0, '0);
    end
  endtask

  task automatic random_traffic(input int n_words);
    int first;
    int sel;
    int len;
    first = words_sent;
    while (words_sent - first < n_words) begin
      sel = $urandom_range(0, 19);
      if (sel < 13) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, sh_addr + 3)
                                          : sh_addr + 1 + $urandom_range(0, 3);
        send_frame(len, $urandom_range(0, 3) != 0, START_CODE);
      end else if (sel < 16) begin
        len = $urandom_range(1, (sh_tmo > 10) ? 12 : sh_tmo + 2);
        repeat (len) send_word(KIND_TICK, rand_byte(), 1'b0, '0);
      end else if (sel < 18) begin
        send_frame($urandom_range(0, 3), 1'b1, 8'($urandom_range(1, 255)));
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(2'($urandom_range(0, 3)), rand_byte(), 1'b0, '0);
      end
    end
  endtask

  task automatic write_cfg(input logic [ADDR_W-1:0] addr, input logic [TMO_W-1:0] tmo);
    in_valid <= 1'b0;
    while (status_pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_START_ADDRESS;
    cfg_wdata <= CFG_W'(addr);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_addr = addr;
    sh_tmo = tmo;
    settings_run++;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      hold_left = pick_gap();
      out_stall <= (hold_left > 0);
      if (hold_left > 0) hold_left--;
    end
  end

  always @(negedge clk) begin
    rx_status_t want;
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && !out_stall) begin
        if (status_pending.size() == 0) begin
          $error("status word with nothing expected");
          errors++;
        end else begin
          want = status_pending.pop_front();
          results_checked++;
          if (out_signal_lost === 1'b1) timeouts_seen++;
          if (out_position !== want.position) begin
            $error("position: expected %0h, got %0h", want.position, out_position);
            errors++;
          end
          if (out_speed !== want.speed) begin
            $error("speed: expected %0h, got %0h", want.speed, out_speed);
            errors++;
          end
          if (out_data_valid !== want.data_valid) begin
            $error("data_valid: expected %0b, got %0b", want.data_valid, out_data_valid);
            errors++;
          end
          if (out_changed !== want.changed) begin
            $error("changed: expected %0b, got %0b", want.changed, out_changed);
            errors++;
          end
          if (out_signal_lost !== want.signal_lost) begin
            $error("signal_lost: expected %0b, got %0b", want.signal_lost, out_signal_lost);
            errors++;
          end
          if (out_frames_seen !== want.frames_seen) begin
            $error("frames_seen: expected %0d, got %0d", want.frames_seen, out_frames_seen);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    directed_rows = '{
      lit(KIND_TICK,   8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0),
      lit(KIND_BYTE,   8'hff, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0),
      lit(KIND_UNUSED, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0),
      lit(KIND_BREAK,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0),
      chk(KIND_BYTE, 8'h5a),
      chk(KIND_BYTE, 8'h00),
      chk(KIND_BYTE, 8'hff),
      lit(KIND_BYTE,   8'h00, 8'hff, 8'h00, 1'b1, 1'b1, 1'b0, 32'd1),
      chk(KIND_BYTE, 8'h37),
      chk(KIND_BREAK, 8'h00),
      chk(KIND_BYTE, 8'h00),
      chk(KIND_BYTE, 8'h00),
      lit(KIND_BYTE,   8'hff, 8'h00, 8'hff, 1'b1, 1'b1, 1'b0, 32'd2),
      chk(KIND_BREAK, 8'hff),
      chk(KIND_BYTE, 8'h00),
      chk(KIND_BYTE, 8'hff),
      chk(KIND_BYTE, 8'h00),
      chk(KIND_BREAK, 8'h00),
      chk(KIND_BYTE, 8'h00),
      chk(KIND_BYTE, 8'hff),
      chk(KIND_BYTE, 8'h00),
      chk(KIND_TICK, 8'h00),
      chk(KIND_BYTE, 8'h80),
      chk(KIND_UNUSED, 8'haa)
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].kind, directed_rows[i].rx_byte,
                directed_rows[i].typed, directed_rows[i].want);

    // start code as position slot, timeout on the first tick
    write_cfg(9'd0, 16'd0);
    random_traffic(60);
    write_cfg(9'd1, 16'd1);
    random_traffic(60);

    // pair address beyond a short frame, timeout too long to fire
    write_cfg(9'd511, 16'hffff);
    send_frame(20, 1'b1, START_CODE);
    repeat (12) send_word(KIND_TICK, rand_byte(), 1'b0, '0);

    repeat (4) begin
      write_cfg(ADDR_W'($urandom_range(1, 16)), TMO_W'($urandom_range(2, 8)));
      random_traffic(50);
    end
    write_cfg(START_ADDRESS_RST, TIMEOUT_TICKS_RST);
    random_traffic(30);

    in_valid <= 1'b0;
    while (status_pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (status_pending.size() != 0) errors++;

    $display("covered %0d line events over %0d register settings, %0d status words checked",
             words_sent, settings_run, results_checked);
    $display("block counted %0d frames, %0d signal loss events seen", sh_frames, timeouts_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
